@@ rtl/lfeii_pkg.sv @@
// Shared types, constants and coefficient tables of the LFE IIR interpolator.
package lfeii_pkg;

  // Run length and filter structure.
  localparam int BaseFactor  = 64;
  localparam int NumSections = 3;
  localparam int CoefPerSec  = 4;
  localparam int PairsBase   = BaseFactor / 2;
  localparam int PairW       = $clog2(BaseFactor);
  localparam int SecW        = $clog2(NumSections);

  // Number formats.
  localparam int SampleW  = 24;
  localparam int PcmW     = 24;
  localparam int HistW    = 56;
  localparam int HistFrac = 20;
  localparam int CoefW    = 30;
  localparam int CoefFrac = 28;
  localparam int HalfW    = HistW / 2;
  localparam int OpW      = HalfW + 1;
  localparam int ProdW    = OpW + CoefW;
  localparam int AccW     = HistW + 4;
  localparam int ScaleSh  = CoefFrac - HistFrac;

  // Sequencer steps inside one section.
  localparam int StepW = 4;
  localparam logic [StepW-1:0] StepFirst    = StepW'(0);
  localparam logic [StepW-1:0] StepSumW     = StepW'(4);
  localparam logic [StepW-1:0] StepCaptureW = StepW'(5);
  localparam logic [StepW-1:0] StepLast     = StepW'(8);

  // Input scale and section coefficients, all signed Q1.28.
  localparam logic signed [CoefW-1:0] ScaleQ28 = 30'sd533063;

  localparam logic signed [CoefW-1:0] SecCoef [NumSections][CoefPerSec] = '{
    '{-30'sd260342956, 30'sd528711567, 30'sd268435456, -30'sd527297382},
    '{-30'sd262742974, 30'sd531114200, 30'sd268435456, -30'sd535578321},
    '{-30'sd266424771, 30'sd534798244, 30'sd268435456, -30'sd536177828}
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE_MUL,
    ST_SCALE_ACC,
    ST_RUN,
    ST_PCM
  } seq_state_e;

  typedef enum logic [2:0] {
    ACC_HOLD,
    ACC_ADD,
    ACC_ADD_SAT,
    ACC_SCALE,
    ACC_ZERO
  } acc_op_e;

  // Datapath control from the sequencer to the MAC and the history file.
  typedef struct packed {
    logic            issue;
    logic            scale_mul;
    logic            lo_half;
    logic            h1_sel;
    logic [1:0]      cidx;
    logic [SecW-1:0] sec;
    acc_op_e         acc_op;
    logic            w_capture;
    logic            hist_shift;
  } mac_ctrl_t;

  // Output stage control from the sequencer to the top level.
  typedef struct packed {
    logic pcm_a_load;
    logic out_load;
    logic last;
  } out_ctrl_t;

endpackage

@@ rtl/lfeii_mac.sv @@
// Shared multiplier with product register and saturating accumulator.
module lfeii_mac (
  input  logic                                 clk_i,
  input  lfeii_pkg::mac_ctrl_t                 ctrl_i,
  input  logic signed [lfeii_pkg::OpW-1:0]     hist_op_i,
  input  logic signed [lfeii_pkg::SampleW-1:0] sample_i,
  output logic signed [lfeii_pkg::AccW-1:0]    acc_o
);
  import lfeii_pkg::*;

  localparam logic signed [AccW-1:0] HistMax = {{(AccW-HistW+1){1'b0}}, {(HistW-1){1'b1}}};
  localparam logic signed [AccW-1:0] HistMin = {{(AccW-HistW+1){1'b1}}, {(HistW-1){1'b0}}};

  logic signed [OpW-1:0]   op_a;
  logic signed [CoefW-1:0] op_b;
  logic signed [ProdW-1:0] prod_d, prod_q;
  logic                    lo_q;
  logic        [ProdW-1:0] prod_rnd28, prod_rnd8;
  logic signed [AccW-1:0]  term, scaled, sum, acc_d, acc_q;

  assign op_a = ctrl_i.scale_mul ? {{(OpW-SampleW){sample_i[SampleW-1]}}, sample_i} : hist_op_i;
  assign op_b = ctrl_i.scale_mul ? ScaleQ28 : SecCoef[ctrl_i.sec][ctrl_i.cidx];
  assign prod_d = op_a * op_b;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.issue) begin
      prod_q <= prod_d;
      lo_q   <= ctrl_i.lo_half;
    end
  end

  // A low partial product is rounded half up back to Q20 before it is summed.
  assign prod_rnd28 = prod_q + (ProdW'(1) << (CoefFrac - 1));
  assign prod_rnd8  = prod_q + (ProdW'(1) << (ScaleSh - 1));

  assign term = lo_q
    ? {{(AccW-ProdW+CoefFrac){prod_rnd28[ProdW-1]}}, prod_rnd28[ProdW-1:CoefFrac]}
    : {{(AccW-ProdW){prod_q[ProdW-1]}}, prod_q};
  assign scaled = {{(AccW-ProdW+ScaleSh){prod_rnd8[ProdW-1]}}, prod_rnd8[ProdW-1:ScaleSh]};
  assign sum = acc_q + term;

  always_comb begin
    acc_d = acc_q;
    case (ctrl_i.acc_op)
      ACC_HOLD:  acc_d = acc_q;
      ACC_ADD:   acc_d = sum;
      ACC_ADD_SAT: begin
        if (sum > HistMax) begin
          acc_d = HistMax;
        end else if (sum < HistMin) begin
          acc_d = HistMin;
        end else begin
          acc_d = sum;
        end
      end
      ACC_SCALE: acc_d = scaled;
      ACC_ZERO:  acc_d = '0;
      default:   acc_d = acc_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

@@ rtl/lfeii_hist.sv @@
// History registers of the three sections and multiplier operand selection.
module lfeii_hist (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lfeii_pkg::mac_ctrl_t              ctrl_i,
  input  logic signed [lfeii_pkg::AccW-1:0] acc_i,
  output logic signed [lfeii_pkg::OpW-1:0]  op_o
);
  import lfeii_pkg::*;

  logic signed [HistW-1:0] h0_q [NumSections];
  logic signed [HistW-1:0] h1_q [NumSections];
  logic signed [HistW-1:0] w_q;
  logic signed [HistW-1:0] h_sel;

  // The section sum w sits in the accumulator only until the next partial product is added; keep it for the shift.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.w_capture) begin
      w_q <= acc_i[HistW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NumSections; s++) begin
        h0_q[s] <= '0;
        h1_q[s] <= '0;
      end
    end else begin
      for (int s = 0; s < NumSections; s++) begin
        if (ctrl_i.hist_shift && ctrl_i.sec == SecW'(s)) begin
          h0_q[s] <= h1_q[s];
          h1_q[s] <= w_q;
        end
      end
    end
  end

  assign h_sel = ctrl_i.h1_sel ? h1_q[ctrl_i.sec] : h0_q[ctrl_i.sec];

  // The low half goes in as an unsigned value, the high half keeps the sign.
  assign op_o = ctrl_i.lo_half ? {1'b0, h_sel[HalfW-1:0]}
                               : {h_sel[HistW-1], h_sel[HistW-1:HalfW]};

endmodule

@@ rtl/lfeii_seq.sv @@
// Sequencer that steps the shared MAC through the scale, sections and output pairs.
module lfeii_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 out_free_i,
  input  logic                 double_rate_i,
  output logic                 idle_o,
  output lfeii_pkg::mac_ctrl_t ctrl_o,
  output lfeii_pkg::out_ctrl_t out_ctrl_o
);
  import lfeii_pkg::*;

  seq_state_e       state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic [SecW-1:0]  sec_q, sec_d;
  logic [PairW-1:0] pair_q, pair_d;
  logic             half_q, half_d;
  logic [PairW-1:0] last_idx;
  logic             last_pair;
  logic             last_sec;

  assign last_idx  = double_rate_i ? PairW'(2 * PairsBase - 1) : PairW'(PairsBase - 1);
  assign last_pair = (pair_q == last_idx);
  assign last_sec  = (sec_q == SecW'(NumSections - 1));
  assign idle_o    = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_SCALE_MUL;
        end
      end
      ST_SCALE_MUL: state_d = ST_SCALE_ACC;
      ST_SCALE_ACC: state_d = ST_RUN;
      ST_RUN: begin
        if (step_q == StepLast && last_sec) begin
          state_d = ST_PCM;
        end
      end
      ST_PCM: begin
        if (!half_q) begin
          state_d = ST_RUN;
        end else if (out_free_i) begin
          state_d = last_pair ? ST_IDLE : ST_RUN;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    step_d = step_q;
    sec_d  = sec_q;
    pair_d = pair_q;
    half_d = half_q;
    case (state_q)
      ST_IDLE: begin
        pair_d = '0;
        half_d = 1'b0;
      end
      ST_SCALE_ACC: begin
        step_d = StepFirst;
        sec_d  = '0;
      end
      ST_RUN: begin
        if (step_q == StepLast) begin
          step_d = StepFirst;
          sec_d  = last_sec ? '0 : sec_q + SecW'(1);
        end else begin
          step_d = step_q + StepW'(1);
        end
      end
      ST_PCM: begin
        if (!half_q) begin
          half_d = 1'b1;
        end else if (out_free_i) begin
          half_d = 1'b0;
          pair_d = pair_q + PairW'(1);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    ctrl_o            = '0;
    ctrl_o.sec        = sec_q;
    ctrl_o.acc_op     = ACC_HOLD;
    out_ctrl_o        = '0;
    out_ctrl_o.last   = last_pair;
    case (state_q)
      ST_SCALE_MUL: begin
        ctrl_o.issue     = 1'b1;
        ctrl_o.scale_mul = 1'b1;
      end
      ST_SCALE_ACC: ctrl_o.acc_op = ACC_SCALE;
      ST_RUN: begin
        // Steps 0-7 issue one partial product each: lo/hi of h0*c0, h1*c1, h0*c2, h1*c3.
        ctrl_o.issue      = (step_q != StepLast);
        ctrl_o.lo_half    = ~step_q[0];
        ctrl_o.h1_sel     = step_q[1];
        ctrl_o.cidx       = step_q[2:1];
        ctrl_o.w_capture  = (step_q == StepCaptureW);
        ctrl_o.hist_shift = (step_q == StepLast);
        case (step_q)
          StepFirst:          ctrl_o.acc_op = ACC_HOLD;
          StepSumW, StepLast: ctrl_o.acc_op = ACC_ADD_SAT;
          default:            ctrl_o.acc_op = ACC_ADD;
        endcase
      end
      ST_PCM: begin
        if (!half_q) begin
          out_ctrl_o.pcm_a_load = 1'b1;
          ctrl_o.acc_op         = ACC_ZERO;
        end else if (out_free_i) begin
          out_ctrl_o.out_load   = 1'b1;
          ctrl_o.acc_op         = ACC_ZERO;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= StepFirst;
      sec_q   <= '0;
      pair_q  <= '0;
      half_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      sec_q   <= sec_d;
      pair_q  <= pair_d;
      half_q  <= half_d;
    end
  end

endmodule

@@ rtl/lfe_iir_interpolator.sv @@
// Top level of the LFE IIR interpolator: handshakes, config register and output pair stage.
//
//   channel  direction  handshake               payload
//   in       request in in_valid_i / in_stall_o lfe_sample_i (24-bit signed)
//   out      result out out_valid_o/out_stall_i first_pcm_o, second_pcm_o, last_pair_o
//   cfg      write in   cfg_valid_i/cfg_ready_o cfg_double_rate_i (1 bit)
//
// One request yields N = 64 PCM samples, or N = 128 with the double rate set, as
// output pairs. The run is serial on the single 29 x 30 bit multiplier, since each
// PCM sample needs 24 partial products over three sections.
// Reset clears the sequencer, the rate register and the six history words at once.
// Output stalls cost nothing until a finished pair finds the output register still full.
module lfe_iir_interpolator (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic signed [lfeii_pkg::SampleW-1:0] lfe_sample_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [lfeii_pkg::PcmW-1:0]    first_pcm_o,
  output logic signed [lfeii_pkg::PcmW-1:0]    second_pcm_o,
  output logic                                 last_pair_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic                                 cfg_double_rate_i
);
  import lfeii_pkg::*;

  localparam int RndW = AccW - HistFrac;

  logic                      idle;
  mac_ctrl_t                 ctrl;
  out_ctrl_t                 out_ctrl;
  logic signed [OpW-1:0]     hist_op;
  logic signed [AccW-1:0]    acc;
  logic signed [SampleW-1:0] sample_q;
  logic                      double_rate_q;
  logic                      out_valid_q, out_valid_d;
  logic                      out_free;
  logic signed [PcmW-1:0]    pcm_a_q;
  logic signed [PcmW-1:0]    first_q, second_q;
  logic                      last_q;
  logic        [AccW-1:0]    rnd_sum;
  logic        [RndW-1:0]    rnd_val;
  logic signed [PcmW-1:0]    pcm_val;

  // A new request is taken only while the sequencer is idle; the rate register
  // is written only then too, so a run always sees one setting throughout.
  assign in_stall_o  = ~idle;
  assign cfg_ready_o = idle;

  // The output register can take a pair when it is empty or drains this cycle.
  assign out_free = ~out_valid_q | ~out_stall_i;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && idle) begin
      sample_q <= lfe_sample_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      double_rate_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      double_rate_q <= cfg_double_rate_i;
    end
  end

  lfeii_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .out_free_i    (out_free),
    .double_rate_i (double_rate_q),
    .idle_o        (idle),
    .ctrl_o        (ctrl),
    .out_ctrl_o    (out_ctrl)
  );

  lfeii_hist u_hist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .acc_i  (acc),
    .op_o   (hist_op)
  );

  lfeii_mac u_mac (
    .clk_i     (clk_i),
    .ctrl_i    (ctrl),
    .hist_op_i (hist_op),
    .sample_i  (sample_q),
    .acc_o     (acc)
  );

  // The last section output is rounded half up to an integer and clipped to 24 bits.
  assign rnd_sum = acc + (AccW'(1) << (HistFrac - 1));
  assign rnd_val = rnd_sum[AccW-1:HistFrac];

  always_comb begin
    if (!rnd_val[RndW-1] && (|rnd_val[RndW-2:PcmW-1])) begin
      pcm_val = {1'b0, {(PcmW-1){1'b1}}};
    end else if (rnd_val[RndW-1] && !(&rnd_val[RndW-2:PcmW-1])) begin
      pcm_val = {1'b1, {(PcmW-1){1'b0}}};
    end else begin
      pcm_val = rnd_val[PcmW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ctrl.pcm_a_load) begin
      pcm_a_q <= pcm_val;
    end
    if (out_ctrl.out_load) begin
      first_q  <= pcm_a_q;
      second_q <= pcm_val;
      last_q   <= out_ctrl.last;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ctrl.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign first_pcm_o  = first_q;
  assign second_pcm_o = second_q;
  assign last_pair_o  = last_q;

endmodule
